[design/bounded_stack_with_bottom_increment_assert.svh]
// Assertion macros for the bounded stack block.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef BOUNDED_STACK_WITH_BOTTOM_INCREMENT_ASSERT_SVH
`define BOUNDED_STACK_WITH_BOTTOM_INCREMENT_ASSERT_SVH

// condition holds at every edge outside reset
`define BSBI_ASSERT_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bsbi: invariant violated");

// consequence holds in the same cycle as the antecedent
`define BSBI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsbi: same-cycle implication violated");

// consequence holds in the cycle after the antecedent
`define BSBI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsbi: next-cycle implication violated");

`endif

[design/bsbi_pkg.sv]
// Package for the bounded stack block: sizes, operation and status codes.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package bsbi_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 7;
	localparam int CMP_W   = (CFG_W > FILL_W) ? CFG_W : FILL_W;

	localparam logic [CFG_W-1:0] MAX_SIZE_RST = CFG_W'(64);

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_INC  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

[design/bsbi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the entries below the top of the stack.
`timescale 1ns / 1ps
`default_nettype none

module bsbi_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/bounded_stack_with_bottom_increment.sv]
// An accepted item reads the RAM at accept and then executes, which may write back below
// the top; its result is registered when execution completes, which waits while the output
// is stalled. No new item is accepted before then, since in_stall is held during execute.
// Reset: fill cleared, max_size set to 64; RAM contents are not cleared (no sweep).
// Depends on bsbi_pkg, bsbi_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_stack_with_bottom_increment_assert.svh"

module bounded_stack_with_bottom_increment
	import bsbi_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wen,
	input  logic [CFG_W-1:0]         cfg_wdata,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [WORD_W-1:0] value,
	input  logic [CNT_W-1:0]         count,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] read_value,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] top_value,
	output logic [FILL_W-1:0]        fill
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    max_size_q;
	logic [FILL_W-1:0]   fill_q;
	logic [WORD_W-1:0]   top_word_q;
	logic [WORD_W-1:0]   top_pend_q;
	op_t                 op_q;
	logic [WORD_W-1:0]   value_q;
	logic [FILL_W-1:0]   n_q;
	logic                inc_top_q;

	logic                out_valid_q;
	logic [WORD_W-1:0]   read_value_q;
	logic [1:0]          status_q;
	logic [WORD_W-1:0]   top_value_q;

	logic                in_acc;
	logic                done;
	logic [FILL_W-1:0]   n_d;
	logic [FILL_W-1:0]   raddr_full;
	logic [ADDR_W-1:0]   raddr;
	logic [2*WORD_W-1:0] rdata;
	logic [WORD_W-1:0]   rd_word;
	logic [WORD_W-1:0]   rd_pend;
	logic                we;
	logic [FILL_W-1:0]   waddr_full;
	logic [2*WORD_W-1:0] wdata;
	logic [CMP_W-1:0]    limit;
	logic                can_push;

	logic [WORD_W-1:0]   nxt_word;
	logic [WORD_W-1:0]   nxt_pend;
	logic [FILL_W-1:0]   nxt_fill;
	logic [WORD_W-1:0]   rd_d;
	status_t             status_d;
	logic [WORD_W-1:0]   top_d;

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign done       = (state_q == S_EXEC) && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign top_value  = top_value_q;
	assign fill       = fill_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MAX_SIZE_RST;
		end else if (cfg_wen) begin
			max_size_q <= cfg_wdata;
		end
	end

	// effective limit: capacity clipped to the built depth
	always_comb begin
		if (CMP_W'(max_size_q) > CMP_W'(DEPTH)) begin
			limit = CMP_W'(DEPTH);
		end else begin
			limit = CMP_W'(max_size_q);
		end
	end
	assign can_push = CMP_W'(fill_q) < limit;

	// accept side: entries covered by an increment, and RAM read address
	always_comb begin
		if (count >= CNT_W'(fill_q)) begin
			n_d = fill_q;
		end else begin
			n_d = count[FILL_W-1:0];
		end
		if (op_t'(func) == OP_POP) begin
			raddr_full = fill_q - FILL_W'(2);
		end else begin
			raddr_full = n_d - FILL_W'(1);
		end
	end
	assign raddr = raddr_full[ADDR_W-1:0];

	assign rd_word = rdata[2*WORD_W-1:WORD_W];
	assign rd_pend = rdata[WORD_W-1:0];

	// execute: fold pending adds, update top cache, write back below the top
	always_comb begin
		we         = 1'b0;
		waddr_full = fill_q - FILL_W'(1);
		wdata      = {top_word_q, top_pend_q};
		nxt_word   = top_word_q;
		nxt_pend   = top_pend_q;
		nxt_fill   = fill_q;
		rd_d       = '0;
		status_d   = ST_OK;
		unique case (op_q)
			OP_PUSH: begin
				if (can_push) begin
					we       = (fill_q != '0);
					nxt_word = value_q;
					nxt_pend = '0;
					nxt_fill = fill_q + FILL_W'(1);
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_POP: begin
				if (fill_q == '0) begin
					rd_d     = '1;
					status_d = ST_EMPTY;
				end else begin
					rd_d     = top_word_q + top_pend_q;
					nxt_fill = fill_q - FILL_W'(1);
					nxt_word = rd_word;
					nxt_pend = rd_pend + top_pend_q;
				end
			end
			OP_INC: begin
				if (n_q != '0) begin
					if (inc_top_q) begin
						nxt_pend = top_pend_q + value_q;
					end else begin
						we         = 1'b1;
						waddr_full = n_q - FILL_W'(1);
						wdata      = {rd_word, rd_pend + value_q};
					end
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
		if (nxt_fill == '0) begin
			top_d = '0;
		end else begin
			top_d = nxt_word + nxt_pend;
		end
	end

	bsbi_ram #(
		.WIDTH  (2 * WORD_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (we && done),
		.waddr (waddr_full[ADDR_W-1:0]),
		.wdata (wdata),
		.re    (in_acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer, stack state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
			read_value_q <= '0;
			status_q     <= '0;
			top_value_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q      <= S_IDLE;
						fill_q       <= nxt_fill;
						out_valid_q  <= 1'b1;
						read_value_q <= rd_d;
						status_q     <= status_d;
						top_value_q  <= top_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and top-entry payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= op_t'(func);
			value_q   <= value;
			n_q       <= n_d;
			inc_top_q <= (n_d == fill_q);
		end
		if (done) begin
			top_word_q <= nxt_word;
			top_pend_q <= nxt_pend;
		end
	end

	`BSBI_ASSERT_HOLDS(a_fill_bound, fill_q <= FILL_W'(DEPTH))
	`BSBI_ASSERT_NEXT(a_accept_exec, in_acc, state_q == S_EXEC)
	`BSBI_ASSERT_SAME(a_full_on_push, done && status_d == ST_FULL, op_q == OP_PUSH)
	`BSBI_ASSERT_SAME(a_empty_pop, done && status_d == ST_EMPTY, fill_q == '0)
	`BSBI_ASSERT_NEXT(a_push_grows, done && op_q == OP_PUSH && status_d == ST_OK,
		fill_q == FILL_W'($past(fill_q) + FILL_W'(1)))

endmodule

`default_nettype wire
